@@ rtl/vpts_pkg.sv @@
// ----------------------------------------------------------------------------
// vpts_pkg
// Shared constants and types for the vertex projection block.
// ----------------------------------------------------------------------------
package vpts_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;

  // command codes
  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_COMMIT  = 2'd1;
  localparam logic [1:0] CMD_PROJECT = 2'd2;

  // matrix selects; anything at or above MAT_COUNT is dropped
  localparam logic [1:0] MAT_MODEL = 2'd0;
  localparam logic [1:0] MAT_VIEW  = 2'd1;
  localparam logic [1:0] MAT_PROJ  = 2'd2;
  localparam logic [1:0] MAT_COUNT = 2'd3;

  // multiplier request
  typedef struct packed {
    logic start;
    logic frac;   // 1: shift product by FRAC_BITS, 0: shift by one
  } mul_ctl_t;

endpackage

@@ rtl/vertex_project_to_screen.sv @@
// ----------------------------------------------------------------------------
// vertex_project_to_screen
// Model/view/projection point transform with viewport mapping, fixed point.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  in      | to block  | in_valid_i / in_ready_o   | cmd, matrix_sel, elem_*,
//          |           |                           | view_*, pos_*
//  out     | from block| out_valid_o / out_ready_i | screen_x/y, clip_w, projected
//
//  Load and commit transfers finish in the accept cycle. A project transfer
//  at Q16.16 in 32 bits runs 78 products on the shared multiplier, each
//  with its matrix reads, plus five divisions on the shared divider.
//  in_ready_o is low while a point is in flight; the finished result sits
//  in the output register until taken, and the next transfer is accepted
//  meanwhile. Reset clears size state; the matrix store is not cleared.
// ----------------------------------------------------------------------------
module vertex_project_to_screen #(
  parameter int WORD_BITS = vpts_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = vpts_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic [1:0]         matrix_sel_i,
  input  logic [3:0]         elem_index_i,
  input  logic signed [31:0] elem_value_i,
  input  logic [15:0]        view_width_i,
  input  logic [15:0]        view_height_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] screen_x_o,
  output logic signed [31:0] screen_y_o,
  output logic signed [31:0] clip_w_o,
  output logic               projected_o
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int XW = WORD_BITS + 34;   // room for sums and 32-bit ports

  localparam logic signed [XW-1:0] WMAX_X = signed'({{(XW-W+1){1'b0}}, {(W-1){1'b1}}});
  localparam logic signed [XW-1:0] WMIN_X = ~WMAX_X;
  localparam logic signed [XW-1:0] I32MAX = signed'({{(XW-31){1'b0}}, {31{1'b1}}});
  localparam logic signed [XW-1:0] I32MIN = ~I32MAX;

  // fixed-point 1.0, saturated when FRAC_BITS fills the word
  localparam logic [W-1:0] ONE_U = (F >= W - 1) ? {1'b0, {(W-1){1'b1}}} : (W'(1) << F);
  // 0.001 rounded, at least one LSB
  localparam int           WLO_RAW = ((1 << F) + 500) / 1000;
  localparam logic [W-1:0] WLO_U   = (WLO_RAW < 1) ? W'(1) : W'(WLO_RAW);

  typedef enum logic [4:0] {
    S_IDLE, S_H_RD, S_H_MUL, S_H_WAIT, S_WD, S_WD_WAIT,
    S_VP_RDA, S_VP_RDB, S_VP_MUL, S_VP_WAIT, S_CL_MUL, S_CL_WAIT,
    S_ND, S_ND_WAIT, S_SX, S_SX_WAIT, S_SY, S_SY_WAIT, S_DONE
  } state_e;

  function automatic logic signed [W-1:0] sat_w(input logic signed [XW-1:0] v);
    logic signed [W-1:0] r;
    if (v > WMAX_X) begin
      r = WMAX_X[W-1:0];
    end else if (v < WMIN_X) begin
      r = WMIN_X[W-1:0];
    end else begin
      r = v[W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] to32(input logic signed [W-1:0] v);
    logic signed [XW-1:0] e;
    logic signed [31:0]   r;
    e = XW'(v);
    if (e > I32MAX) begin
      r = I32MAX[31:0];
    end else if (e < I32MIN) begin
      r = I32MIN[31:0];
    end else begin
      r = e[31:0];
    end
    return r;
  endfunction

  // matrix store: model at 0, view at 16, projection at 32
  logic [W-1:0] mem [48];
  logic [5:0]   raddr;
  logic [W-1:0] rd_q;

  state_e              state_q;
  logic [1:0]          r_q, c_q, k_q;
  logic signed [W+1:0] acc_q, acc2_q;
  logic signed [W-1:0] v_q [3];
  logic signed [W-1:0] h_q [4];
  logic signed [W-1:0] world_q [3];
  logic signed [W-1:0] opa_q, vp_q, clip0_q, clip1_q, w_q;
  logic signed [W-1:0] ndx_q, ndy_q, sx_q, sy_q;
  logic                proj_q;
  logic [15:0]         width_q, height_q;
  logic                committed_q;
  logic                out_valid_q;
  logic signed [31:0]  out_x_q, out_y_q, out_w_q;
  logic                out_p_q;

  logic                in_fire;
  vpts_pkg::mul_ctl_t  mul_ctl;
  logic signed [W-1:0] mul_a, mul_b, mul_res, div_a, div_res;
  logic                mul_done, div_start, div_done;
  logic signed [W+1:0] mul_sum, acc2_sum;
  logic signed [W-1:0] one_s, wlo_s, clip_sat;

  assign one_s      = signed'(ONE_U);
  assign wlo_s      = signed'(WLO_U);
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign mul_sum    = acc_q + (W+2)'(mul_res);
  assign acc2_sum   = acc2_q + (W+2)'(mul_res);
  assign clip_sat   = sat_w(XW'(mul_sum));

  // operand steering for the shared units
  always_comb begin
    mul_ctl   = '{start: 1'b0, frac: 1'b1};
    mul_a     = signed'(rd_q);
    mul_b     = signed'(rd_q);
    div_start = 1'b0;
    div_a     = h_q[k_q];
    raddr     = {2'b00, r_q, c_q};
    unique case (state_q)
      S_H_MUL: begin
        mul_ctl.start = 1'b1;
        mul_a = (r_q == 2'd3) ? one_s : v_q[r_q];
      end
      S_VP_RDA: raddr = {2'b01, r_q, k_q};
      S_VP_RDB: raddr = {2'b10, k_q, c_q};
      S_VP_MUL: begin
        mul_ctl.start = 1'b1;
        mul_a = opa_q;
      end
      S_CL_MUL: begin
        mul_ctl.start = 1'b1;
        mul_a = (r_q == 2'd3) ? one_s : world_q[r_q];
        mul_b = vp_q;
      end
      S_WD: div_start = 1'b1;
      S_ND: begin
        div_start = 1'b1;
        div_a = (k_q == 2'd0) ? clip0_q : clip1_q;
      end
      S_SX: begin
        mul_ctl = '{start: 1'b1, frac: 1'b0};
        mul_a   = sat_w(XW'(ndx_q) + XW'(one_s));
        mul_b   = signed'(W'(width_q));
      end
      S_SY: begin
        mul_ctl = '{start: 1'b1, frac: 1'b0};
        mul_a   = sat_w(XW'(one_s) - XW'(ndy_q));
        mul_b   = signed'(W'(height_q));
      end
      default: ;
    endcase
  end

  vpts_mul #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mul_ctl),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  vpts_div #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .a_i     (div_a),
    .b_i     ((state_q == S_ND) ? w_q : h_q[3]),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  // matrix memory, registered read
  always_ff @(posedge clk_i) begin
    if (in_fire && cmd_i == vpts_pkg::CMD_LOAD && matrix_sel_i < vpts_pkg::MAT_COUNT) begin
      mem[{matrix_sel_i, elem_index_i}] <= sat_w(XW'(elem_value_i));
    end
    rd_q <= mem[raddr];
  end

  // small operand files, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire && cmd_i == vpts_pkg::CMD_PROJECT) begin
      v_q[0] <= sat_w(XW'(pos_x_i));
      v_q[1] <= sat_w(XW'(pos_y_i));
      v_q[2] <= sat_w(XW'(pos_z_i));
    end
    if (state_q == S_H_WAIT && mul_done && r_q == 2'd3) begin
      h_q[c_q] <= clip_sat;
    end
    if (state_q == S_WD_WAIT && div_done && k_q != 2'd3) begin
      world_q[k_q] <= div_res;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      r_q         <= 2'd0;
      c_q         <= 2'd0;
      k_q         <= 2'd0;
      acc_q       <= '0;
      acc2_q      <= '0;
      opa_q       <= '0;
      vp_q        <= '0;
      clip0_q     <= '0;
      clip1_q     <= '0;
      w_q         <= '0;
      ndx_q       <= '0;
      ndy_q       <= '0;
      sx_q        <= '0;
      sy_q        <= '0;
      proj_q      <= 1'b0;
      width_q     <= '0;
      height_q    <= '0;
      committed_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_w_q     <= '0;
      out_p_q     <= 1'b0;
    end else begin
      // S_DONE reloads the output register itself
      if (out_valid_q && out_ready_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            case (cmd_i)
              vpts_pkg::CMD_COMMIT: begin
                width_q     <= view_width_i;
                height_q    <= view_height_i;
                committed_q <= 1'b1;
              end
              vpts_pkg::CMD_PROJECT: begin
                if (!committed_q || width_q == '0 || height_q == '0) begin
                  sx_q    <= '0;
                  sy_q    <= '0;
                  w_q     <= '0;
                  proj_q  <= 1'b0;
                  state_q <= S_DONE;
                end else begin
                  proj_q  <= 1'b1;
                  r_q     <= 2'd0;
                  c_q     <= 2'd0;
                  acc_q   <= '0;
                  state_q <= S_H_RD;
                end
              end
              default: ;   // load handled by the memory; code three ignored
            endcase
          end
        end
        // h = [x y z 1] * model
        S_H_RD:  state_q <= S_H_MUL;
        S_H_MUL: state_q <= S_H_WAIT;
        S_H_WAIT: begin
          if (mul_done) begin
            if (r_q == 2'd3) begin
              acc_q <= '0;
              r_q   <= 2'd0;
              if (c_q == 2'd3) begin
                k_q     <= 2'd0;
                state_q <= S_WD;
              end else begin
                c_q     <= c_q + 2'd1;
                state_q <= S_H_RD;
              end
            end else begin
              acc_q   <= mul_sum;
              r_q     <= r_q + 2'd1;
              state_q <= S_H_RD;
            end
          end
        end
        // world = h.xyz / h.w
        S_WD: state_q <= S_WD_WAIT;
        S_WD_WAIT: begin
          if (div_done) begin
            if (k_q == 2'd2) begin
              r_q     <= 2'd0;
              c_q     <= 2'd0;
              k_q     <= 2'd0;
              acc_q   <= '0;
              acc2_q  <= '0;
              state_q <= S_VP_RDA;
            end else begin
              k_q     <= k_q + 2'd1;
              state_q <= S_WD;
            end
          end
        end
        // vp[r][c] = sum_k view[r][k] * proj[k][c], then clip += coef * vp
        S_VP_RDA: state_q <= S_VP_RDB;
        S_VP_RDB: begin
          opa_q   <= signed'(rd_q);
          state_q <= S_VP_MUL;
        end
        S_VP_MUL: state_q <= S_VP_WAIT;
        S_VP_WAIT: begin
          if (mul_done) begin
            if (k_q == 2'd3) begin
              vp_q    <= sat_w(XW'(acc2_sum));
              acc2_q  <= '0;
              k_q     <= 2'd0;
              state_q <= S_CL_MUL;
            end else begin
              acc2_q  <= acc2_sum;
              k_q     <= k_q + 2'd1;
              state_q <= S_VP_RDA;
            end
          end
        end
        S_CL_MUL: state_q <= S_CL_WAIT;
        S_CL_WAIT: begin
          if (mul_done) begin
            if (r_q == 2'd3) begin
              acc_q <= '0;
              r_q   <= 2'd0;
              // clip.z is never used: columns x, y, w only
              case (c_q)
                2'd0: clip0_q <= clip_sat;
                2'd1: clip1_q <= clip_sat;
                default: w_q  <= (clip_sat < wlo_s) ? wlo_s : clip_sat;
              endcase
              if (c_q == 2'd3) begin
                k_q     <= 2'd0;
                state_q <= S_ND;
              end else begin
                c_q     <= (c_q == 2'd1) ? 2'd3 : c_q + 2'd1;
                state_q <= S_VP_RDA;
              end
            end else begin
              acc_q   <= mul_sum;
              r_q     <= r_q + 2'd1;
              state_q <= S_VP_RDA;
            end
          end
        end
        // ndc = clip / w
        S_ND: state_q <= S_ND_WAIT;
        S_ND_WAIT: begin
          if (div_done) begin
            if (k_q == 2'd0) begin
              ndx_q   <= div_res;
              k_q     <= 2'd1;
              state_q <= S_ND;
            end else begin
              ndy_q   <= div_res;
              state_q <= S_SX;
            end
          end
        end
        // pixel scaling: t * size / 2
        S_SX: state_q <= S_SX_WAIT;
        S_SX_WAIT: begin
          if (mul_done) begin
            sx_q    <= mul_res;
            state_q <= S_SY;
          end
        end
        S_SY: state_q <= S_SY_WAIT;
        S_SY_WAIT: begin
          if (mul_done) begin
            sy_q    <= mul_res;
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_x_q     <= to32(sx_q);
            out_y_q     <= to32(sy_q);
            out_w_q     <= to32(w_q);
            out_p_q     <= proj_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign screen_x_o  = out_x_q;
  assign screen_y_o  = out_y_q;
  assign clip_w_o    = out_w_q;
  assign projected_o = out_p_q;

endmodule

@@ rtl/vpts_mul.sv @@
// ----------------------------------------------------------------------------
// vpts_mul
// Iterative sign-magnitude multiplier, four half-word partial products.
// ----------------------------------------------------------------------------
module vpts_mul #(
  parameter int WORD_BITS = vpts_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = vpts_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  vpts_pkg::mul_ctl_t          ctl_i,
  input  logic signed [WORD_BITS-1:0] a_i,
  input  logic signed [WORD_BITS-1:0] b_i,
  output logic                        done_o,
  output logic signed [WORD_BITS-1:0] res_o
);

  localparam int W  = WORD_BITS;
  localparam int H  = (WORD_BITS + 1) / 2;
  localparam int PW = 4 * H;

  logic [2*H-1:0]       x_q, y_q;
  logic                 neg_q, frac_q, busy_q, fin_q, done_q;
  logic [1:0]           cnt_q;
  logic [PW-1:0]        p_q;
  logic signed [W-1:0]  res_q;

  logic [W-1:0]         a_mag, b_mag;
  logic [H-1:0]         xs, ys;
  logic [2*H-1:0]       pp;
  logic [PW-1:0]        ppw, pp_sh, rr, lim, m;
  logic [W-1:0]         mw;

  always_comb begin
    a_mag = a_i[W-1] ? W'(-a_i) : W'(a_i);
    b_mag = b_i[W-1] ? W'(-b_i) : W'(b_i);
    xs    = cnt_q[1] ? x_q[2*H-1:H] : x_q[H-1:0];
    ys    = cnt_q[0] ? y_q[2*H-1:H] : y_q[H-1:0];
    pp    = xs * ys;
    ppw   = PW'(pp);
    if (cnt_q == 2'd0) begin
      pp_sh = ppw;
    end else if (cnt_q == 2'd3) begin
      pp_sh = ppw << (2 * H);
    end else begin
      pp_sh = ppw << H;
    end
    rr  = frac_q ? (p_q >> FRAC_BITS) : (p_q >> 1);
    lim = neg_q ? (PW'(1) << (W - 1)) : ((PW'(1) << (W - 1)) - PW'(1));
    m   = (rr > lim) ? lim : rr;
    mw  = m[W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 2'd0;
      neg_q  <= 1'b0;
      frac_q <= 1'b0;
      x_q    <= '0;
      y_q    <= '0;
      p_q    <= '0;
      res_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        x_q    <= (2*H)'(a_mag);
        y_q    <= (2*H)'(b_mag);
        neg_q  <= a_i[W-1] ^ b_i[W-1];
        frac_q <= ctl_i.frac;
        p_q    <= '0;
        cnt_q  <= 2'd0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        p_q   <= p_q + pp_sh;
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
        res_q  <= neg_q ? signed'(-mw) : signed'(mw);
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

@@ rtl/vpts_div.sv @@
// ----------------------------------------------------------------------------
// vpts_div
// Restoring fixed-point divider, one quotient bit per cycle, saturating.
// ----------------------------------------------------------------------------
module vpts_div #(
  parameter int WORD_BITS = vpts_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = vpts_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [WORD_BITS-1:0] a_i,
  input  logic signed [WORD_BITS-1:0] b_i,
  output logic                        done_o,
  output logic signed [WORD_BITS-1:0] res_o
);

  localparam int W  = WORD_BITS;
  localparam int N  = WORD_BITS + FRAC_BITS;
  localparam int CW = $clog2(N + 1);

  logic [N-1:0]         dvd_q;
  logic [W-1:0]         nb_q, rem_q;
  logic                 neg_q, busy_q, fin_q, done_q;
  logic [CW-1:0]        cnt_q;
  logic signed [W-1:0]  res_q;

  logic [W-1:0]         a_mag, b_mag, mw;
  logic [W:0]           rem_sh;
  logic                 qbit;
  logic [N-1:0]         lim, m;

  always_comb begin
    a_mag  = a_i[W-1] ? W'(-a_i) : W'(a_i);
    b_mag  = b_i[W-1] ? W'(-b_i) : W'(b_i);
    rem_sh = {rem_q, dvd_q[N-1]};
    qbit   = (rem_sh >= {1'b0, nb_q});
    lim    = neg_q ? (N'(1) << (W - 1)) : ((N'(1) << (W - 1)) - N'(1));
    m      = (dvd_q > lim) ? lim : dvd_q;
    mw     = m[W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      neg_q  <= 1'b0;
      dvd_q  <= '0;
      nb_q   <= '0;
      rem_q  <= '0;
      res_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (a_i == '0) begin
          res_q  <= '0;
          done_q <= 1'b1;
        end else if (b_i == '0) begin
          res_q  <= a_i[W-1] ? signed'({1'b1, {(W-1){1'b0}}})
                             : signed'({1'b0, {(W-1){1'b1}}});
          done_q <= 1'b1;
        end else begin
          dvd_q  <= N'(a_mag) << FRAC_BITS;
          nb_q   <= b_mag;
          rem_q  <= '0;
          neg_q  <= a_i[W-1] ^ b_i[W-1];
          cnt_q  <= CW'(N);
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        rem_q <= qbit ? W'(rem_sh - {1'b0, nb_q}) : rem_sh[W-1:0];
        dvd_q <= {dvd_q[N-2:0], qbit};
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
        res_q  <= neg_q ? signed'(-mw) : signed'(mw);
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for vertex_project_to_screen. A directed table covers
// the reset state, degenerate viewports, ignored commands and the
// saturation and clamp corners. Random load/commit/project traffic follows,
// with idle gaps on both channels. Every result is checked against a
// fixed-point projection predictor, or against the result given in its row.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint WMAX  = 64'sd2147483647;
  localparam longint WMIN  = -64'sd2147483648;
  localparam longint ONE   = 64'sd65536;
  localparam longint W_EPS = 64'sd66;   // 0.001 in Q16.16, rounded
  localparam logic [1:0] CMD_NONE = 2'd3;

  typedef struct {
    logic signed [31:0] sx, sy, cw;
    logic               prj;
  } screen_pt_t;

  typedef struct {
    logic [1:0]         cmd, sel;
    logic [3:0]         idx;
    logic signed [31:0] val;
    logic [15:0]        vw, vh;
    logic signed [31:0] px, py, pz;
    bit                 typed;   // expected result given in the row
    screen_pt_t         res;
  } vtx_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] cmd = CMD_NONE, msel = vpts_pkg::MAT_MODEL;
  logic [3:0] eidx = '0;
  logic signed [31:0] eval = '0, pos_x = '0, pos_y = '0, pos_z = '0;
  logic [15:0] vwidth = '0, vheight = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] scr_x, scr_y, clip_w;
  logic projected;

  vertex_project_to_screen u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .cmd_i(cmd), .matrix_sel_i(msel), .elem_index_i(eidx), .elem_value_i(eval),
    .view_width_i(vwidth), .view_height_i(vheight),
    .pos_x_i(pos_x), .pos_y_i(pos_y), .pos_z_i(pos_z),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .screen_x_o(scr_x), .screen_y_o(scr_y), .clip_w_o(clip_w),
    .projected_o(projected)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow state of the block
  longint mat_shadow [48];
  longint size_w, size_h;
  bit     size_ok;

  screen_pt_t pending_pts [$];
  int  n_err = 0, n_pts = 0, n_xfer = 0;
  bit  hold_req = 1'b0;

  function automatic longint sat_word(longint v);
    if (v > WMAX) return WMAX;
    if (v < WMIN) return WMIN;
    return v;
  endfunction

  function automatic longint apply_sign(longint unsigned m, bit neg);
    longint unsigned lim;
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    if (m > lim) m = lim;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned abs_val(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  // product truncated toward zero, then saturated
  function automatic longint fx_mul(longint a, longint b);
    return apply_sign((abs_val(a) * abs_val(b)) >> 16, (a < 0) != (b < 0));
  endfunction

  function automatic longint fx_div(longint a, longint b);
    if (a == 0) return 0;
    if (b == 0) return a < 0 ? WMIN : WMAX;
    return apply_sign((abs_val(a) << 16) / abs_val(b), (a < 0) != (b < 0));
  endfunction

  function automatic longint scale_px(longint t, longint dim);
    return apply_sign((abs_val(t) * longint'(dim)) >> 1, t < 0);
  endfunction

  function automatic screen_pt_t project_point(longint x, longint y, longint z);
    screen_pt_t p;
    longint v[4], h[4], wld[3], vp[16], clp[4], s, w;
    v[0] = x; v[1] = y; v[2] = z; v[3] = ONE;
    for (int c = 0; c < 4; c++) begin
      s = 0;
      for (int r = 0; r < 4; r++) s += fx_mul(v[r], mat_shadow[r*4+c]);
      h[c] = sat_word(s);
    end
    for (int k = 0; k < 3; k++) wld[k] = fx_div(h[k], h[3]);
    // combined view * projection, each element saturated
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) begin
        s = 0;
        for (int k = 0; k < 4; k++)
          s += fx_mul(mat_shadow[16+r*4+k], mat_shadow[32+k*4+c]);
        vp[r*4+c] = sat_word(s);
      end
    for (int c = 0; c < 4; c++) begin
      s = fx_mul(ONE, vp[12+c]);
      for (int r = 0; r < 3; r++) s += fx_mul(wld[r], vp[r*4+c]);
      clp[c] = sat_word(s);
    end
    w = clp[3] < W_EPS ? W_EPS : clp[3];
    p.sx  = 32'(scale_px(sat_word(fx_div(clp[0], w) + ONE), size_w));
    p.sy  = 32'(scale_px(sat_word(ONE - fx_div(clp[1], w)), size_h));
    p.cw  = 32'(w);
    p.prj = 1'b1;
    return p;
  endfunction

  // update shadow state for one accepted transfer; queue its result if any
  task automatic track_xfer(vtx_cmd_t it);
    screen_pt_t p;
    n_xfer++;
    case (it.cmd)
      vpts_pkg::CMD_LOAD:
        if (it.sel < vpts_pkg::MAT_COUNT) mat_shadow[it.sel*16 + it.idx] = it.val;
      vpts_pkg::CMD_COMMIT: begin
        size_w = it.vw; size_h = it.vh; size_ok = 1'b1;
      end
      vpts_pkg::CMD_PROJECT: begin
        if (!size_ok || size_w == 0 || size_h == 0) p = '{0, 0, 0, 1'b0};
        else p = project_point(it.px, it.py, it.pz);
        pending_pts.push_back(it.typed ? it.res : p);
      end
      default: ;
    endcase
  endtask

  // one transfer on the input channel, after gap idle cycles
  task automatic send_cmd(vtx_cmd_t it, int gap);
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cmd <= it.cmd; msel <= it.sel; eidx <= it.idx; eval <= it.val;
    vwidth <= it.vw; vheight <= it.vh;
    pos_x <= it.px; pos_y <= it.py; pos_z <= it.pz;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    track_xfer(it);
  endtask

  function automatic vtx_cmd_t mk(logic [1:0] c, logic [1:0] s, logic [3:0] i,
                                  logic signed [31:0] v, logic [15:0] w,
                                  logic [15:0] h, logic signed [31:0] x,
                                  logic signed [31:0] y, logic signed [31:0] z);
    vtx_cmd_t it;
    it = '{c, s, i, v, w, h, x, y, z, 1'b0, '{0, 0, 0, 1'b0}};
    return it;
  endfunction

  function automatic vtx_cmd_t mk_typed(vtx_cmd_t it, screen_pt_t r);
    it.typed = 1'b1;
    it.res = r;
    return it;
  endfunction

  function automatic int pick_gap(bit busy);
    int r;
    if (!busy) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 90);
  endfunction

  function automatic logic signed [31:0] small_fx();
    return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
  endfunction

  // result checker
  always @(posedge clk) begin
    screen_pt_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pts.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("ERROR: result with nothing outstanding");
      end else begin
        e = pending_pts.pop_front();
        n_pts++;
        if (scr_x !== e.sx || scr_y !== e.sy || clip_w !== e.cw ||
            projected !== e.prj) begin
          n_err++;
          if (n_err <= 10)
            $display("ERROR: point %0d exp x=%h y=%h w=%h p=%b got x=%h y=%h w=%h p=%b",
                     n_pts, e.sx, e.sy, e.cw, e.prj, scr_x, scr_y, clip_w, projected);
        end
      end
    end
  end

  // output ready: random stalls, plus one long hold-off on request
  initial begin
    int hold_cnt;
    int r;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < 4000; hold_cnt++) @(negedge clk);
        hold_req = 1'b0;
      end
      r = $urandom_range(0, 99);
      if (r < 70) out_ready <= 1'b1;
      else if (r < 95) out_ready <= 1'b0;
      else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(20, 200)) @(negedge clk);
      end
    end
  end

  initial begin
    #50ms;
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    vtx_cmd_t dir [$];
    vtx_cmd_t it;
    int r, k;
    bit busy;
    size_w = 0; size_h = 0; size_ok = 1'b0;
    foreach (mat_shadow[i]) mat_shadow[i] = 0;

    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed, part one: no matrix reads possible yet
    dir.push_back(mk_typed(mk(vpts_pkg::CMD_PROJECT, 0, 0, 0, 0, 0, 1, 2, 3),
                           '{0, 0, 0, 0}));
    dir.push_back(mk(CMD_NONE, 0, 0, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(vpts_pkg::CMD_COMMIT, 0, 0, 0, 0, 100, 0, 0, 0));
    dir.push_back(mk_typed(mk(vpts_pkg::CMD_PROJECT, 0, 0, 0, 0, 0, 5, 5, 5),
                           '{0, 0, 0, 0}));
    dir.push_back(mk(vpts_pkg::CMD_COMMIT, 0, 0, 0, 100, 0, 0, 0, 0));
    dir.push_back(mk_typed(mk(vpts_pkg::CMD_PROJECT, 0, 0, 0, 0, 0, 5, 5, 5),
                           '{0, 0, 0, 0}));
    foreach (dir[i]) send_cmd(dir[i], 0);
    dir.delete();

    // every matrix to identity before any real projection
    for (int s = 0; s < 3; s++)
      for (int e = 0; e < 16; e++)
        send_cmd(mk(vpts_pkg::CMD_LOAD, s[1:0], e[3:0],
                    (e % 5 == 0) ? 32'sh0001_0000 : 32'sh0, 0, 0, 0, 0, 0), 0);

    // directed, part two: identity mapping, extremes, w clamp, divide by zero
    dir.push_back(mk(vpts_pkg::CMD_COMMIT, 0, 0, 0, 640, 480, 0, 0, 0));
    dir.push_back(mk_typed(mk(vpts_pkg::CMD_PROJECT, 0, 0, 0, 0, 0, 0, 0, 0),
                           '{32'sd320 <<< 16, 32'sd240 <<< 16, 32'sh0001_0000, 1'b1}));
    dir.push_back(mk(vpts_pkg::CMD_LOAD, vpts_pkg::MAT_COUNT, 4'd5, 32'sh7fff_ffff,
                     0, 0, 0, 0, 0));
    dir.push_back(mk(vpts_pkg::CMD_COMMIT, 0, 0, 0, 16'hffff, 16'hffff, 0, 0, 0));
    dir.push_back(mk(vpts_pkg::CMD_PROJECT, 0, 0, 0, 0, 0, 32'sh7fff_ffff,
                     32'sh7fff_ffff, 32'sh7fff_ffff));
    dir.push_back(mk(vpts_pkg::CMD_PROJECT, 0, 0, 0, 0, 0, 32'sh8000_0000,
                     32'sh8000_0000, 32'sh8000_0000));
    dir.push_back(mk(vpts_pkg::CMD_LOAD, vpts_pkg::MAT_PROJ, 4'd15, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(vpts_pkg::CMD_PROJECT, 0, 0, 0, 0, 0, 32'sh0000_8000,
                     -32'sh0000_4000, 0));
    dir.push_back(mk(vpts_pkg::CMD_LOAD, vpts_pkg::MAT_MODEL, 4'd15, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(vpts_pkg::CMD_PROJECT, 0, 0, 0, 0, 0, 32'sh0001_0000,
                     -32'sh0002_0000, 0));
    dir.push_back(mk(vpts_pkg::CMD_PROJECT, 0, 0, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(vpts_pkg::CMD_LOAD, vpts_pkg::MAT_MODEL, 4'd15, 32'sh8000_0000,
                     0, 0, 0, 0, 0));
    dir.push_back(mk(vpts_pkg::CMD_PROJECT, 0, 0, 0, 0, 0, 32'sh0003_0000,
                     32'sh0001_0000, 1));
    dir.push_back(mk(vpts_pkg::CMD_LOAD, vpts_pkg::MAT_MODEL, 4'd15, 32'sh7fff_ffff,
                     0, 0, 0, 0, 0));
    dir.push_back(mk(vpts_pkg::CMD_LOAD, vpts_pkg::MAT_PROJ, 4'd15, 32'sh0001_0000,
                     0, 0, 0, 0, 0));
    dir.push_back(mk(vpts_pkg::CMD_PROJECT, 0, 0, 0, 0, 0, 32'sh0003_0000,
                     32'sh0001_0000, 1));
    dir.push_back(mk(vpts_pkg::CMD_LOAD, vpts_pkg::MAT_MODEL, 4'd15, 32'sh0001_0000,
                     0, 0, 0, 0, 0));
    foreach (dir[i]) send_cmd(dir[i], pick_gap(1'b1));

    // random traffic
    busy = 1'b1;
    for (int n = 0; n < 450; n++) begin
      if (n % 60 == 0) busy = $urandom_range(0, 2) != 0;
      if (n == 40) hold_req = 1'b1;   // sender keeps going, block backs up
      if (n == 200) begin
        @(negedge clk) in_valid <= 1'b0;
        wait (pending_pts.size() == 0);
      end
      r = $urandom_range(0, 99);
      it = mk(vpts_pkg::CMD_LOAD, 0, 0, 0, 0, 0, 0, 0, 0);
      it.vw = 16'($urandom); it.vh = 16'($urandom);
      it.px = small_fx(); it.py = small_fx(); it.pz = small_fx();
      it.sel = 2'($urandom_range(0, 2)); it.idx = 4'($urandom); it.val = small_fx();
      if (r < 50) begin
        // mostly near-identity content keeps results in range
        k = $urandom_range(0, 9);
        if (k == 0) it.val = $urandom;
        else if (it.idx % 5 == 0 && k < 7) it.val = 32'sh0001_0000 + (small_fx() >>> 3);
      end else if (r < 58) begin
        it.cmd = vpts_pkg::CMD_COMMIT;
        k = $urandom_range(0, 9);
        if (k < 6) begin
          it.vw = 16'($urandom_range(1, 2048)); it.vh = 16'($urandom_range(1, 2048));
        end else if (k == 6) it.vw = '0;
        else if (k == 7) it.vh = '0;
      end else if (r < 90) begin
        it.cmd = vpts_pkg::CMD_PROJECT;
        if ($urandom_range(0, 7) == 0) begin
          it.px = $urandom; it.py = $urandom; it.pz = $urandom;
        end
      end else if (r < 95) begin
        it.sel = vpts_pkg::MAT_COUNT; it.val = $urandom;
      end else begin
        it.cmd = CMD_NONE;
      end
      send_cmd(it, pick_gap(busy));
    end
    @(negedge clk) in_valid <= 1'b0;

    wait (pending_pts.size() == 0);
    repeat (1200) @(posedge clk);
    $display("run: %0d transfers accepted, %0d points checked, %0d mismatches",
             n_xfer, n_pts, n_err);
    if (n_err == 0 && pending_pts.size() == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end
endmodule

@@ vertex_project_to_screen.f @@
rtl/vpts_pkg.sv
rtl/vpts_mul.sv
rtl/vpts_div.sv
rtl/vertex_project_to_screen.sv
sim/testbench.sv
